### design/grdd_pkg.sv
// Shared types, constants and helper functions of the gaze region dwell detector.
`timescale 1ns / 1ps
`default_nettype none

package grdd_pkg;

  // Region count limits
  localparam int MAX_REGIONS         = 3;
  localparam int NUM_REGIONS_DEFAULT = 3;

  // Bundle queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_REGION0   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd3;

  // Event kinds
  localparam logic [1:0] KIND_CONFIRM = 2'd0;
  localparam logic [1:0] KIND_ENDED   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // Event slots per bundle: confirm/leave and end-of-record per region, then summary
  localparam int NUM_SLOTS    = 2 * MAX_REGIONS + 1;
  localparam int SUMMARY_SLOT = 2 * MAX_REGIONS;

  // Reset values of the registers
  localparam logic [CFG_DATA_W-1:0] BOUNDS_RESET [MAX_REGIONS] = '{
    64'h041B_0255_032B_0120,
    64'h0233_0000_0355_00E5,
    64'h03B8_0255_06E8_0355
  };
  localparam logic [31:0] THRESHOLD_RESET = 32'd3000;

  // Divide by 1000: (d * MULT) >> SHIFT is exact for every 32-bit d
  localparam logic [28:0] DIV1000_MULT  = 29'd274877907;
  localparam int          DIV1000_SHIFT = 38;
  localparam int          START_W       = 23;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  // Region rectangle, packed as in the bounds register
  typedef struct packed {
    logic signed [15:0] bottom;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] left;
  } bounds_t;

  // Input transaction
  typedef struct packed {
    logic signed [15:0] gaze_x;
    logic signed [15:0] gaze_y;
    logic [31:0]        sample_time_ms;
    logic               end_of_record;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]         event_kind;
    logic [1:0]         region;
    logic [START_W-1:0] start_offset_s;
    logic [31:0]        duration_ms;
    logic [15:0]        entries_region0;
    logic [15:0]        entries_region1;
    logic [15:0]        entries_region2;
    logic [15:0]        entries_total;
    logic [15:0]        fixations_total;
    logic               last_of_run;
  } out_item_t;

  // Events of one region caused by one sample
  typedef struct packed {
    logic        ev_a;        // confirm or leave
    logic        a_ended;     // ev_a is a leave (ended) event
    logic        ev_b;        // closing ended event at end of record
    logic [31:0] dur_a;
    logic [31:0] dur_b;
    logic [31:0] start_diff;  // dwell start minus record first time, floored at 0
  } region_ev_t;

  // Everything the back needs to emit the results of one sample
  typedef struct packed {
    region_ev_t [MAX_REGIONS-1:0]        reg_ev;
    logic                                summary;
    logic [MAX_REGIONS-1:0][15:0]        entries;
    logic [15:0]                         entries_total;
    logic [15:0]                         fixations_total;
  } bundle_t;

  function automatic logic [31:0] diff_floor0(input logic [31:0] a, input logic [31:0] b);
    return (a >= b) ? (a - b) : 32'd0;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == SAT16) ? v : v + 16'd1;
  endfunction

  function automatic logic is_inside(input bounds_t b, input logic signed [15:0] x,
                                     input logic signed [15:0] y);
    return (b.left < x) && (x < b.right) && (b.top < y) && (y < b.bottom);
  endfunction

endpackage

`default_nettype wire

### design/grdd_chan_if.sv
// Valid/ready channel interface carrying one payload per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface grdd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/grdd_cfg.sv
// Configuration registers: region bounds and dwell threshold.
`timescale 1ns / 1ps
`default_nettype none

module grdd_cfg #(
  parameter int NUM_REGIONS = grdd_pkg::NUM_REGIONS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write_en,
  input  wire logic [grdd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [grdd_pkg::CFG_DATA_W-1:0]       cfg_data,
  output grdd_pkg::bounds_t [NUM_REGIONS-1:0]        bounds,
  output logic [31:0]                                threshold
);

  // Register writes; indexes without a register are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_REGIONS; r++) begin
        bounds[r] <= grdd_pkg::BOUNDS_RESET[r];
      end
      threshold <= grdd_pkg::THRESHOLD_RESET;
    end else if (cfg_write_en) begin
      for (int r = 0; r < NUM_REGIONS; r++) begin
        if (cfg_index == grdd_pkg::REG_REGION0 + grdd_pkg::CFG_INDEX_W'(r)) begin
          bounds[r] <= cfg_data;
        end
      end
      if (cfg_index == grdd_pkg::REG_THRESHOLD) begin
        threshold <= cfg_data[31:0];
      end
    end
  end

endmodule

`default_nettype wire

### design/grdd_front.sv
// Front: accepts samples, tracks dwell state per region and builds event bundles.
`timescale 1ns / 1ps
`default_nettype none

module grdd_front #(
  parameter int NUM_REGIONS = grdd_pkg::NUM_REGIONS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  grdd_chan_if.sink                                  gaze,
  input  wire grdd_pkg::bounds_t [NUM_REGIONS-1:0]   bounds,
  input  wire logic [31:0]                           threshold,
  input  wire logic                                  q_full,
  output logic                                       push,
  output grdd_pkg::bundle_t                          bundle
);

  // Dwell state
  logic [NUM_REGIONS-1:0]       inside_flag, inside_flag_next;
  logic [NUM_REGIONS-1:0]       awaiting, awaiting_next;
  logic [NUM_REGIONS-1:0][31:0] dwell_start, dwell_start_next;
  logic [NUM_REGIONS-1:0][15:0] entry_count, entry_count_next;
  logic [15:0]                  fixation_tally, fixation_tally_next;
  logic [31:0]                  record_first_time, record_first_time_next;
  logic [31:0]                  previous_time, previous_time_next;
  logic                         first_pending;

  logic accept;
  logic any_event;

  assign gaze.ready = !q_full;
  assign accept     = gaze.valid && gaze.ready;
  assign push       = accept && any_event;

  // Per-region update and event classification
  always_comb begin
    logic        in_now, enter, ac, conf, leave, eor_ev, eor;
    logic [31:0] t, ds, dur_now, dur_prev, rft;
    logic [15:0] entry_upd;
    logic [17:0] total_sum, tally_sum;
    logic [1:0]  n_conf;

    t         = gaze.payload.sample_time_ms;
    eor       = gaze.payload.end_of_record;
    rft       = first_pending ? t : record_first_time;
    total_sum = '0;
    n_conf    = '0;
    bundle    = '0;
    any_event = 1'b0;

    for (int r = 0; r < NUM_REGIONS; r++) begin
      in_now   = grdd_pkg::is_inside(bounds[r], gaze.payload.gaze_x, gaze.payload.gaze_y);
      enter    = in_now && !inside_flag[r];
      ds       = enter ? t : dwell_start[r];
      ac       = enter || awaiting[r];
      dur_now  = grdd_pkg::diff_floor0(t, ds);
      dur_prev = grdd_pkg::diff_floor0(previous_time, dwell_start[r]);
      conf     = in_now && ac && (dur_now >= threshold);
      leave    = !in_now && inside_flag[r] && (dur_prev >= threshold);
      eor_ev   = eor && in_now && (dur_now >= threshold);

      entry_upd = (enter && !first_pending) ? grdd_pkg::sat_inc16(entry_count[r])
                                            : entry_count[r];

      inside_flag_next[r] = !eor && in_now;
      awaiting_next[r]    = !eor && in_now && ac && !conf;
      dwell_start_next[r] = eor ? 32'd0 : ds;
      entry_count_next[r] = eor ? 16'd0 : entry_upd;

      bundle.reg_ev[r].ev_a       = conf || leave;
      bundle.reg_ev[r].a_ended    = leave;
      bundle.reg_ev[r].ev_b       = eor_ev;
      bundle.reg_ev[r].dur_a      = leave ? dur_prev : 32'd0;
      bundle.reg_ev[r].dur_b      = dur_now;
      bundle.reg_ev[r].start_diff = grdd_pkg::diff_floor0(ds, rft);
      bundle.entries[r]           = entry_upd;

      total_sum = total_sum + 18'(entry_upd);
      n_conf    = n_conf + {1'b0, conf};
      any_event = any_event || conf || leave || eor_ev;
    end

    // Record totals, saturating
    tally_sum = 18'(fixation_tally) + 18'(n_conf);
    bundle.entries_total   = (total_sum > 18'(grdd_pkg::SAT16)) ? grdd_pkg::SAT16
                                                                : total_sum[15:0];
    bundle.fixations_total = (tally_sum > 18'(grdd_pkg::SAT16)) ? grdd_pkg::SAT16
                                                                : tally_sum[15:0];
    bundle.summary = eor;
    any_event      = any_event || eor;

    fixation_tally_next    = eor ? 16'd0 : bundle.fixations_total;
    record_first_time_next = eor ? 32'd0 : rft;
    previous_time_next     = eor ? 32'd0 : t;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_flag       <= '0;
      awaiting          <= '0;
      dwell_start       <= '0;
      entry_count       <= '0;
      fixation_tally    <= '0;
      record_first_time <= '0;
      previous_time     <= '0;
      first_pending     <= 1'b1;
    end else if (accept) begin
      inside_flag       <= inside_flag_next;
      awaiting          <= awaiting_next;
      dwell_start       <= dwell_start_next;
      entry_count       <= entry_count_next;
      fixation_tally    <= fixation_tally_next;
      record_first_time <= record_first_time_next;
      previous_time     <= previous_time_next;
      first_pending     <= gaze.payload.end_of_record;
    end
  end

endmodule

`default_nettype wire

### design/grdd_queue.sv
// Short FIFO of event bundles between front and back.
`timescale 1ns / 1ps
`default_nettype none

module grdd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire grdd_pkg::bundle_t push_data,
  input  wire logic              pop,
  output grdd_pkg::bundle_t      head,
  output logic                   empty,
  output logic                   full
);

  localparam int DEPTH = grdd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  grdd_pkg::bundle_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/grdd_back.sv
// Back: walks the head bundle one event at a time, scales the start offset, drives results.
`timescale 1ns / 1ps
`default_nettype none

module grdd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire grdd_pkg::bundle_t head,
  input  wire logic              q_empty,
  output logic                   pop,
  grdd_chan_if.source            result
);

  localparam int NS = grdd_pkg::NUM_SLOTS;

  typedef struct packed {
    logic [1:0]                          kind;
    logic [1:0]                          region;
    logic [31:0]                         start_diff;
    logic [31:0]                         dur;
    logic [grdd_pkg::MAX_REGIONS-1:0][15:0] entries;
    logic [15:0]                         entries_total;
    logic [15:0]                         fixations_total;
    logic                                last;
  } stage_t;

  logic [NS-1:0] done;
  logic [NS-1:0] slots, pending, pick;
  logic          found, last_pick, take;
  stage_t        sel, s1;
  logic          s1_valid, s1_ready, s2_load;
  logic [60:0]   prod;

  // Slot pick: lowest pending event of the head bundle
  always_comb begin
    slots = '0;
    for (int r = 0; r < grdd_pkg::MAX_REGIONS; r++) begin
      slots[2*r]   = head.reg_ev[r].ev_a;
      slots[2*r+1] = head.reg_ev[r].ev_b;
    end
    slots[grdd_pkg::SUMMARY_SLOT] = head.summary;
    pending = q_empty ? '0 : (slots & ~done);

    pick  = '0;
    found = 1'b0;
    for (int i = 0; i < NS; i++) begin
      if (pending[i] && !found) begin
        pick[i] = 1'b1;
        found   = 1'b1;
      end
    end
    last_pick = ((pending & ~pick) == '0);
  end

  // Field selection for the picked event
  always_comb begin
    sel = '0;
    for (int r = 0; r < grdd_pkg::MAX_REGIONS; r++) begin
      if (pick[2*r]) begin
        sel.kind       = head.reg_ev[r].a_ended ? grdd_pkg::KIND_ENDED : grdd_pkg::KIND_CONFIRM;
        sel.region     = 2'(r);
        sel.start_diff = head.reg_ev[r].start_diff;
        sel.dur        = head.reg_ev[r].dur_a;
      end
      if (pick[2*r+1]) begin
        sel.kind       = grdd_pkg::KIND_ENDED;
        sel.region     = 2'(r);
        sel.start_diff = head.reg_ev[r].start_diff;
        sel.dur        = head.reg_ev[r].dur_b;
      end
    end
    if (pick[grdd_pkg::SUMMARY_SLOT]) begin
      sel.kind            = grdd_pkg::KIND_SUMMARY;
      sel.entries         = head.entries;
      sel.entries_total   = head.entries_total;
      sel.fixations_total = head.fixations_total;
    end
    sel.last = last_pick;
  end

  // Two-stage elastic pipeline: S1 holds the event, output register holds the result
  assign s2_load  = s1_valid && (!result.valid || result.ready);
  assign s1_ready = !s1_valid || s2_load;
  assign take     = found && s1_ready;
  assign pop      = take && last_pick;

  // Progress through the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (take) begin
      done <= last_pick ? '0 : (done | pick);
    end
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= found;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1 <= sel;
    end
  end

  // Whole seconds by reciprocal multiplication
  assign prod = {29'd0, s1.start_diff} * {32'd0, grdd_pkg::DIV1000_MULT};

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s2_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      result.payload.event_kind      <= s1.kind;
      result.payload.region          <= s1.region;
      result.payload.start_offset_s  <= prod[grdd_pkg::DIV1000_SHIFT +: grdd_pkg::START_W];
      result.payload.duration_ms     <= s1.dur;
      result.payload.entries_region0 <= s1.entries[0];
      result.payload.entries_region1 <= s1.entries[1];
      result.payload.entries_region2 <= s1.entries[2];
      result.payload.entries_total   <= s1.entries_total;
      result.payload.fixations_total <= s1.fixations_total;
      result.payload.last_of_run     <= s1.last;
    end
  end

endmodule

`default_nettype wire

### design/gaze_region_dwell_detector.sv
// Gaze region dwell detector: top level.
//
// Samples arrive on the gaze channel (valid/ready, payload grdd_pkg::in_item_t)
// and events leave on the result channel (payload grdd_pkg::out_item_t); a
// transaction completes when valid and ready are both high at a clock edge.
// Registers are written through cfg_write_en / cfg_index / cfg_data; the user
// must do so only while idle; the block does not enforce it. The front
// classifies each sample against all regions in the cycle it is accepted and
// queues one bundle of events (up to seven) in a four-entry queue. The back
// takes one event per cycle, unless stalled, through two register stages. A
// sample is accepted every cycle while the queue has room; the back drains one
// result per cycle while the receiver takes them; a bundle stays queued until
// all its events are taken, and the queue absorbs bursts. Samples causing no
// result never enter the queue. When the receiver stalls, the output register
// holds its result, the pipeline and then the queue fill, and gaze.ready drops.
// Synchronous reset restores register defaults and clears all dwell state, the
// queue and the pipeline at once; the block is ready the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module gaze_region_dwell_detector #(
  parameter int NUM_REGIONS = grdd_pkg::NUM_REGIONS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write_en,
  input  wire logic [grdd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [grdd_pkg::CFG_DATA_W-1:0]  cfg_data,
  grdd_chan_if.sink                             gaze,
  grdd_chan_if.source                           result
);

  grdd_pkg::bounds_t [NUM_REGIONS-1:0] bounds;
  logic [31:0]                         threshold;
  grdd_pkg::bundle_t                   push_bundle, head;
  logic                                push, pop, q_empty, q_full;

  grdd_cfg #(.NUM_REGIONS(NUM_REGIONS)) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .bounds       (bounds),
    .threshold    (threshold)
  );

  grdd_front #(.NUM_REGIONS(NUM_REGIONS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .gaze      (gaze),
    .bounds    (bounds),
    .threshold (threshold),
    .q_full    (q_full),
    .push      (push),
    .bundle    (push_bundle)
  );

  grdd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_bundle),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  grdd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

`default_nettype wire

### design/grdd_chk.sv
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module grdd_chk (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                result_valid,
  input wire logic                result_ready,
  input wire grdd_pkg::out_item_t result_payload
);

  // A stalled result stays and holds its payload
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_payload))
    else $error("result changed while stalled");

  // The summary always closes the run of a sample
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_payload.event_kind == grdd_pkg::KIND_SUMMARY
      |-> result_payload.last_of_run)
    else $error("summary not last of run");

  // Totals and the region 0 count appear on summaries only
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_payload.event_kind != grdd_pkg::KIND_SUMMARY
      |-> result_payload.entries_total == 16'd0 && result_payload.fixations_total == 16'd0
          && result_payload.entries_region0 == 16'd0)
    else $error("counts on a region event");

  // Summaries and confirms carry no duration
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_payload.event_kind == grdd_pkg::KIND_SUMMARY
                     || result_payload.event_kind == grdd_pkg::KIND_CONFIRM)
      |-> result_payload.duration_ms == 32'd0)
    else $error("duration on a summary or confirm");

endmodule

bind gaze_region_dwell_detector grdd_chk u_grdd_chk (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_payload (result.payload)
);

`default_nettype wire

### bench/gaze_region_dwell_detector_tb.sv
// Self-checking testbench for the gaze region dwell detector.
`timescale 1ns / 1ps

module gaze_region_dwell_detector_tb;
  import grdd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Configuration port
  logic                   cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  // Channel drive
  logic       tx_valid = 1'b0;
  in_item_t   tx_item  = '0;
  logic       tx_taken = 1'b0;
  logic       rx_ready = 1'b0;

  grdd_chan_if #(.payload_t(in_item_t))  gaze_ch ();
  grdd_chan_if #(.payload_t(out_item_t)) result_ch ();

  assign gaze_ch.valid   = tx_valid;
  assign gaze_ch.payload = tx_item;
  assign result_ch.ready = rx_ready;

  gaze_region_dwell_detector i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .gaze         (gaze_ch),
    .result       (result_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_item_t  sample_queue[$];
  out_item_t expected_events[$];
  int        mismatch_count = 0;
  int        cycle_no = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_mode = 0;

  // Predictor copy of registers and dwell state
  bounds_t     rgn_bounds [3];
  logic [31:0] dwell_thr;
  logic        in_rgn [3];
  logic        pend_confirm [3];
  logic [31:0] dwell_t0 [3];
  logic [15:0] entry_cnt [3];
  logic [15:0] fix_cnt;
  logic [31:0] rec_t0;
  logic [31:0] prev_t;
  logic        new_record;

  function automatic logic [31:0] elapsed_ms(input logic [31:0] later, input logic [31:0] early);
    return (later < early) ? 32'd0 : later - early;
  endfunction

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Strictly between the bounds on both axes, signed compare
  function automatic logic hits_region(input bounds_t b, input logic signed [15:0] x,
                                       input logic signed [15:0] y);
    return (x > b.left) && (x < b.right) && (y > b.top) && (y < b.bottom);
  endfunction

  function automatic out_item_t dwell_event(input logic [1:0] kind, input int r,
                                            input logic [31:0] dur);
    out_item_t ev;
    logic [31:0] secs;
    ev = '0;
    secs = elapsed_ms(dwell_t0[r], rec_t0) / 32'd1000;
    ev.event_kind     = kind;
    ev.region         = 2'(r);
    ev.start_offset_s = secs[START_W-1:0];
    ev.duration_ms    = dur;
    return ev;
  endfunction

  task automatic clear_dwell_state();
    for (int r = 0; r < 3; r++) begin
      in_rgn[r]       = 1'b0;
      pend_confirm[r] = 1'b0;
      dwell_t0[r]     = '0;
      entry_cnt[r]    = '0;
    end
    fix_cnt    = '0;
    rec_t0     = '0;
    prev_t     = '0;
    new_record = 1'b1;
  endtask

  // Work out the events one accepted sample causes and queue them
  task automatic predict_dwell_events(input in_item_t s);
    out_item_t   batch [7];
    int          n;
    logic [31:0] t;
    logic [31:0] d;
    logic        first;
    logic [17:0] tot;
    n = 0;
    t = s.sample_time_ms;
    first = new_record;
    if (first) rec_t0 = t;
    for (int r = 0; r < 3; r++) begin
      if (hits_region(rgn_bounds[r], s.gaze_x, s.gaze_y)) begin
        if (!in_rgn[r]) begin
          if (!first) entry_cnt[r] = bump16(entry_cnt[r]);
          dwell_t0[r]     = t;
          in_rgn[r]       = 1'b1;
          pend_confirm[r] = 1'b1;
        end
        if (pend_confirm[r] && elapsed_ms(t, dwell_t0[r]) >= dwell_thr) begin
          pend_confirm[r] = 1'b0;
          fix_cnt = bump16(fix_cnt);
          batch[n] = dwell_event(KIND_CONFIRM, r, 32'd0);
          n++;
        end
      end else begin
        // leaving: dwell length runs to the previous sample
        if (in_rgn[r]) begin
          d = elapsed_ms(prev_t, dwell_t0[r]);
          if (d >= dwell_thr) begin
            batch[n] = dwell_event(KIND_ENDED, r, d);
            n++;
          end
        end
        in_rgn[r]       = 1'b0;
        pend_confirm[r] = 1'b0;
      end
      // closing event of a dwell still open at end of record
      if (s.end_of_record && in_rgn[r]) begin
        d = elapsed_ms(t, dwell_t0[r]);
        if (d >= dwell_thr) begin
          batch[n] = dwell_event(KIND_ENDED, r, d);
          n++;
        end
      end
    end
    prev_t = t;
    new_record = 1'b0;
    if (s.end_of_record) begin
      batch[n] = '0;
      batch[n].event_kind      = KIND_SUMMARY;
      batch[n].entries_region0 = entry_cnt[0];
      batch[n].entries_region1 = entry_cnt[1];
      batch[n].entries_region2 = entry_cnt[2];
      tot = 18'(entry_cnt[0]) + 18'(entry_cnt[1]) + 18'(entry_cnt[2]);
      batch[n].entries_total   = (tot > 18'd65535) ? 16'hFFFF : tot[15:0];
      batch[n].fixations_total = fix_cnt;
      n++;
      clear_dwell_state();
    end
    if (n > 0) batch[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_events.push_back(batch[i]);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("cycle %0d: %s mismatch, got %0d expected %0d", cycle_no, what, got, want);
    mismatch_count++;
  endtask

  // Watchdog
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sender: bursts of random length, random gaps between them
  always @(negedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (tx_valid && !tx_taken) begin
      // hold until the transaction completes
    end else if (gap_left > 0) begin
      tx_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (sample_queue.size() > 0) begin
      tx_item  <= sample_queue.pop_front();
      tx_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 30);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      tx_valid <= 1'b0;
    end
  end

  // Receiver: stall pattern changes, picked at random among four
  always @(negedge clk) begin
    if (rst) begin
      rx_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: rx_ready <= 1'b1;
        1: rx_ready <= (cycle_no % 4 != 0);
        2: rx_ready <= 1'($urandom_range(0, 1));
        default: rx_ready <= (cycle_no % 16 < 4);
      endcase
      if (cycle_no % 128 == 0) stall_mode <= $urandom_range(0, 3);
    end
  end

  // Monitor: check results against expectations, predict on accepted samples
  always @(posedge clk) begin : monitor
    out_item_t got;
    out_item_t want;
    tx_taken <= gaze_ch.valid && gaze_ch.ready;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.payload;
        if (expected_events.size() == 0) begin
          flag_mismatch("unexpected result, event_kind", got.event_kind, 0);
        end else begin
          want = expected_events.pop_front();
          if (got.event_kind !== want.event_kind)
            flag_mismatch("event_kind", got.event_kind, want.event_kind);
          if (got.region !== want.region)
            flag_mismatch("region", got.region, want.region);
          if (got.start_offset_s !== want.start_offset_s)
            flag_mismatch("start_offset_s", got.start_offset_s, want.start_offset_s);
          if (got.duration_ms !== want.duration_ms)
            flag_mismatch("duration_ms", got.duration_ms, want.duration_ms);
          if (got.entries_region0 !== want.entries_region0)
            flag_mismatch("entries_region0", got.entries_region0, want.entries_region0);
          if (got.entries_region1 !== want.entries_region1)
            flag_mismatch("entries_region1", got.entries_region1, want.entries_region1);
          if (got.entries_region2 !== want.entries_region2)
            flag_mismatch("entries_region2", got.entries_region2, want.entries_region2);
          if (got.entries_total !== want.entries_total)
            flag_mismatch("entries_total", got.entries_total, want.entries_total);
          if (got.fixations_total !== want.fixations_total)
            flag_mismatch("fixations_total", got.fixations_total, want.fixations_total);
          if (got.last_of_run !== want.last_of_run)
            flag_mismatch("last_of_run", got.last_of_run, want.last_of_run);
        end
      end
      if (gaze_ch.valid && gaze_ch.ready) predict_dwell_events(gaze_ch.payload);
    end
  end

  // Register write, mirrored into the predictor; only called while idle
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    if (idx == REG_THRESHOLD) dwell_thr = val[31:0];
    else rgn_bounds[idx] = val;
  endtask

  // Wait until nothing is left to send or to receive, then let the block settle.
  // Polled at the rising edge, where the sender's signals are settled.
  task automatic wait_idle();
    @(posedge clk);
    while (sample_queue.size() != 0 || tx_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic push_sample(input int x, input int y, input logic [31:0] t,
                             input logic eor);
    in_item_t s;
    s.gaze_x         = 16'(x);
    s.gaze_y         = 16'(y);
    s.sample_time_ms = t;
    s.end_of_record  = eor;
    sample_queue.push_back(s);
  endtask

  // Uniform pick in [lo, hi], lo <= hi
  function automatic logic signed [15:0] pick_between(input int lo, input int hi);
    return 16'(lo + int'($urandom % (hi - lo + 1)));
  endfunction

  function automatic logic signed [15:0] extreme_coord();
    case ($urandom_range(0, 3))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      default: return -16'sd1;
    endcase
  endfunction

  function automatic bounds_t rand_bounds();
    bounds_t b;
    int x0;
    int y0;
    if ($urandom_range(0, 7) == 0) begin
      b = {$urandom, $urandom};
      return b;
    end
    x0 = int'($urandom_range(0, 3000)) - 1500;
    y0 = int'($urandom_range(0, 3000)) - 1500;
    b.left   = 16'(x0);
    b.right  = 16'(x0 + int'($urandom_range(2, 1200)));
    b.top    = 16'(y0);
    b.bottom = 16'(y0 + int'($urandom_range(2, 1200)));
    return b;
  endfunction

  // Gaze position aimed at one region: inside, on an edge, extreme or anywhere
  task automatic aim_point(input int r, output logic signed [15:0] x,
                           output logic signed [15:0] y);
    bounds_t b;
    int pick;
    int l;
    int rr;
    int tp;
    int bt;
    b  = rgn_bounds[r];
    l  = b.left;
    rr = b.right;
    tp = b.top;
    bt = b.bottom;
    pick = $urandom_range(0, 99);
    if (pick < 55 && rr - l >= 2 && bt - tp >= 2) begin
      x = pick_between(l + 1, rr - 1);
      y = pick_between(tp + 1, bt - 1);
    end else if (pick < 70) begin
      if ($urandom_range(0, 1)) begin
        x = $urandom_range(0, 1) ? b.left : b.right;
        y = pick_between((tp < bt) ? tp : bt, (tp < bt) ? bt : tp);
      end else begin
        y = $urandom_range(0, 1) ? b.top : b.bottom;
        x = pick_between((l < rr) ? l : rr, (l < rr) ? rr : l);
      end
    end else if (pick < 80) begin
      x = extreme_coord();
      y = extreme_coord();
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
    end
  endtask

  // Mostly small forward steps; sometimes long, still, backwards or huge
  function automatic logic [31:0] next_time(input logic [31:0] t);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return t;
    if (pick < 10) return t - $urandom_range(1, 3000);
    if (pick < 13) return t + $urandom;
    if (pick < 35) return t + $urandom_range(1000, 6000);
    return t + $urandom_range(1, 900);
  endfunction

  // One complete recording, wandering between regions
  task automatic push_record(input int len);
    logic [31:0]        t;
    logic signed [15:0] x;
    logic signed [15:0] y;
    int                 aim;
    t   = $urandom_range(0, 1) ? 32'($urandom_range(0, 10000)) : $urandom;
    aim = $urandom_range(0, 2);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 4) == 0) aim = $urandom_range(0, 2);
      aim_point(aim, x, y);
      push_sample(x, y, t, i == len - 1);
      t = next_time(t);
    end
  endtask

  initial begin
    bounds_t b;
    int      made;
    int      len;
    logic    drained_mid;
    for (int r = 0; r < 3; r++) rgn_bounds[r] = BOUNDS_RESET[r];
    dwell_thr = THRESHOLD_RESET;
    clear_dwell_state();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: first sample dwell, confirm, leave, edge, backwards time,
    // entry into each region, closing event and summary at end of record
    push_sample(500, 800, 1000, 1'b0);
    push_sample(500, 800, 2500, 1'b0);
    push_sample(500, 800, 4000, 1'b0);
    push_sample(100, 100, 5000, 1'b0);
    push_sample(288, 800, 5100, 1'b0);
    push_sample(500, 300, 5200, 1'b0);
    push_sample(500, 300, 4000, 1'b0);
    push_sample(500, 300, 9000, 1'b0);
    push_sample(1000, 700, 9500, 1'b0);
    push_sample(1000, 700, 13000, 1'b1);
    wait_idle();

    // Threshold zero: confirm on entry, zero-length closing event; extreme fields
    write_reg(REG_THRESHOLD, 64'd0);
    push_sample(-32768, -32768, 32'd0, 1'b0);
    push_sample(32767, 32767, 32'hFFFF_FFFF, 1'b0);
    push_sample(500, 800, 32'hFFFF_FFFF, 1'b1);
    wait_idle();

    // Dwell ends after the threshold is lowered mid-record, never confirmed
    write_reg(REG_THRESHOLD, 64'd100000);
    push_sample(500, 800, 32'd0, 1'b0);
    push_sample(500, 800, 32'd5000, 1'b0);
    wait_idle();
    write_reg(REG_THRESHOLD, 64'd1000);
    push_sample(0, 0, 32'd6000, 1'b0);
    push_sample(0, 0, 32'd7000, 1'b1);
    wait_idle();

    // Largest threshold met only by the full time span
    write_reg(REG_THRESHOLD, 64'hFFFF_FFFF);
    push_sample(500, 800, 32'd0, 1'b0);
    push_sample(500, 800, 32'hFFFF_FFFF, 1'b1);
    wait_idle();

    // Random phases, each under its own register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          for (int r = 0; r < 3; r++) write_reg(REG_REGION0 + 2'(r), BOUNDS_RESET[r]);
          write_reg(REG_THRESHOLD, 64'(THRESHOLD_RESET));
        end
        1: begin
          for (int r = 0; r < 3; r++) write_reg(REG_REGION0 + 2'(r), rand_bounds());
          write_reg(REG_THRESHOLD, 64'd0);
        end
        2: begin
          // full-range region, a zero-width one, and a random one
          b.left = -16'sd32768; b.right = 16'sd32767;
          b.top = -16'sd32768; b.bottom = 16'sd32767;
          write_reg(REG_REGION0, b);
          b = rand_bounds();
          b.right = b.left;
          write_reg(REG_REGION0 + 2'd1, b);
          write_reg(REG_REGION0 + 2'd2, rand_bounds());
          write_reg(REG_THRESHOLD, 64'hFFFF_FFFF);
        end
        3: begin
          // first two regions coincide
          b = rand_bounds();
          write_reg(REG_REGION0, b);
          write_reg(REG_REGION0 + 2'd1, b);
          write_reg(REG_REGION0 + 2'd2, rand_bounds());
          write_reg(REG_THRESHOLD, 64'd1);
        end
        4: begin
          for (int r = 0; r < 3; r++) write_reg(REG_REGION0 + 2'(r), rand_bounds());
          write_reg(REG_THRESHOLD, 64'($urandom_range(200, 6000)));
        end
        default: begin
          write_reg(REG_REGION0, rand_bounds());
          // top above bottom: nothing inside
          b = rand_bounds();
          b.top = b.bottom + 16'sd1;
          write_reg(REG_REGION0 + 2'd1, b);
          write_reg(REG_REGION0 + 2'd2, {$urandom, $urandom});
          write_reg(REG_THRESHOLD, 64'($urandom_range(2000, 4000)));
        end
      endcase
      made = 0;
      drained_mid = 1'b0;
      while (made < 64) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 25);
        push_record(len);
        made += len;
        // sender holds off until every pending result is out
        if (!drained_mid && made >= 32) begin
          wait_idle();
          drained_mid = 1'b1;
        end
      end
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
